@@ rtl/sbi_pkg.sv @@
// ============================================================================
// Segment/box intersection - shared definitions
// Default coordinate width and the per-axis status flags that travel
// between pipeline stages.
// ============================================================================
package sbi_pkg;

    // Default coordinate width in bits (signed fixed point, 4 fractional bits).
    localparam int COORD_BITS_DEFAULT = 16;

    // Per-axis slab status, computed once the axis parameters are normalised.
    typedef struct packed {
        logic zero;    // segment has no extent along this axis
        logic in_slab; // coordinate lies in the closed slab (used when zero)
        logic lo_ok;   // entry parameter is not beyond t = 1
        logic hi_ok;   // exit parameter is not before t = 0
    } t_slab_flags;

endpackage

@@ rtl/sbi_slab.sv @@
// ============================================================================
// Segment/box intersection - one slab axis
// Two register stages: slab offsets and delta, then sign normalisation,
// entry/exit numerators, denominator and range flags.
// ============================================================================
module sbi_slab #(
    parameter int COORD_BITS = sbi_pkg::COORD_BITS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_en1,
    input  logic                          i_en2,
    input  logic signed [COORD_BITS-1:0]  i_start,
    input  logic signed [COORD_BITS-1:0]  i_end,
    input  logic signed [COORD_BITS-1:0]  i_corner,
    input  logic        [COORD_BITS-2:0]  i_extent,
    output logic signed [COORD_BITS+1:0]  o_n1,
    output logic signed [COORD_BITS+1:0]  o_n2,
    output logic        [COORD_BITS-1:0]  o_den,
    output sbi_pkg::t_slab_flags          o_flags
);

    localparam int NW = COORD_BITS + 2;

    logic signed [COORD_BITS:0]   r_na, n_na;
    logic signed [NW-1:0]         r_nb, n_nb;
    logic signed [COORD_BITS:0]   r_del, n_del;

    logic signed [NW-1:0]         r_n1, r_n2;
    logic        [COORD_BITS-1:0] r_den;
    sbi_pkg::t_slab_flags         r_flags;

    logic                         neg;
    logic signed [COORD_BITS:0]   del_mag;
    logic        [COORD_BITS-1:0] den;
    logic signed [NW-1:0]         na_w, a, b, n1, n2;
    sbi_pkg::t_slab_flags         n_flags;

    // Stage 1: distances from the start point to both slab planes, and delta.
    always_comb begin
        n_na  = $signed({i_corner[COORD_BITS-1], i_corner})
                - $signed({i_start[COORD_BITS-1], i_start});
        n_nb  = $signed({n_na[COORD_BITS], n_na}) + $signed({3'b000, i_extent});
        n_del = $signed({i_end[COORD_BITS-1], i_end})
                - $signed({i_start[COORD_BITS-1], i_start});
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_na  <= n_na;
            r_nb  <= n_nb;
            r_del <= n_del;
        end
    end

    // Stage 2: make the denominator positive, order the two plane parameters.
    always_comb begin
        neg     = r_del[COORD_BITS];
        del_mag = neg ? -r_del : r_del;
        den     = del_mag[COORD_BITS-1:0];
        na_w    = $signed({r_na[COORD_BITS], r_na});
        a       = neg ? -na_w : na_w;
        b       = neg ? -r_nb : r_nb;
        n1      = (a < b) ? a : b;
        n2      = (a < b) ? b : a;
        n_flags.zero    = (r_del == '0);
        n_flags.in_slab = (r_na <= 0) && (r_nb >= 0);
        n_flags.lo_ok   = (n1 <= $signed({2'b00, den}));
        n_flags.hi_ok   = (n2 >= 0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_n1    <= n1;
            r_n2    <= n2;
            r_den   <= den;
            r_flags <= n_flags;
        end
    end

    assign o_n1    = r_n1;
    assign o_n2    = r_n2;
    assign o_den   = r_den;
    assign o_flags = r_flags;

endmodule

@@ rtl/sbi_cross.sv @@
// ============================================================================
// Segment/box intersection - cross products
// One register stage of four multipliers that turn the comparisons of the
// X and Y entry/exit fractions into comparisons of integer products.
// ============================================================================
module sbi_cross #(
    parameter int COORD_BITS = sbi_pkg::COORD_BITS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [COORD_BITS+1:0]      i_n1x,
    input  logic signed [COORD_BITS+1:0]      i_n2x,
    input  logic        [COORD_BITS-1:0]      i_dx,
    input  logic signed [COORD_BITS+1:0]      i_n1y,
    input  logic signed [COORD_BITS+1:0]      i_n2y,
    input  logic        [COORD_BITS-1:0]      i_dy,
    output logic signed [2*COORD_BITS+2:0]    o_x_in_y,  // n1x * dy
    output logic signed [2*COORD_BITS+2:0]    o_y_out_x, // n2y * dx
    output logic signed [2*COORD_BITS+2:0]    o_y_in_x,  // n1y * dx
    output logic signed [2*COORD_BITS+2:0]    o_x_out_y  // n2x * dy
);

    localparam int PW = 2 * COORD_BITS + 3;

    logic signed [COORD_BITS:0] dxs, dys;
    logic signed [PW-1:0]       r_p0, r_p1, r_p2, r_p3;

    assign dxs = $signed({1'b0, i_dx});
    assign dys = $signed({1'b0, i_dy});

    // Entry of one axis against exit of the other, over the common denominator.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= PW'(i_n1x) * PW'(dys);
            r_p1 <= PW'(i_n2y) * PW'(dxs);
            r_p2 <= PW'(i_n1y) * PW'(dxs);
            r_p3 <= PW'(i_n2x) * PW'(dys);
        end
    end

    assign o_x_in_y  = r_p0;
    assign o_y_out_x = r_p1;
    assign o_y_in_x  = r_p2;
    assign o_x_out_y = r_p3;

endmodule

@@ rtl/segment_box_intersect_top.sv @@
// ============================================================================
// Segment/box intersection - top level
// Each accepted input transaction passes the slab, normalisation, cross-product
// and hit registers. Throughput: one test per cycle; each stage holds a valid
// bit and advances when the stage after it is empty or moving, so a stalled
// result does not block the stages behind it while they hold bubbles.
// Reset (synchronous, active low) clears every valid bit; no other state.
// ============================================================================
module segment_box_intersect_top #(
    parameter int COORD_BITS = sbi_pkg::COORD_BITS_DEFAULT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y, box_left, box_top,
    // box_width, box_height, then two zero bits of padding
    input  logic [8*COORD_BITS-1:0] s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // hit, then seven zero bits of padding
    output logic [7:0]              m_axis_tdata
);

    localparam int C  = COORD_BITS;
    localparam int NW = C + 2;
    localparam int PW = 2 * C + 3;

    // Field unpacking.
    logic signed [C-1:0] sx, sy, ex, ey, bl, bt;
    logic        [C-2:0] bw, bh;

    assign sx = s_axis_tdata[C-1:0];
    assign sy = s_axis_tdata[2*C-1:C];
    assign ex = s_axis_tdata[3*C-1:2*C];
    assign ey = s_axis_tdata[4*C-1:3*C];
    assign bl = s_axis_tdata[5*C-1:4*C];
    assign bt = s_axis_tdata[6*C-1:5*C];
    assign bw = s_axis_tdata[7*C-2:6*C];
    assign bh = s_axis_tdata[8*C-3:7*C-1];

    // Pipeline occupancy and per-stage advance.
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !r_v4 || m_axis_tready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // Stages 1 and 2, one slab unit per axis.
    logic signed [NW-1:0] n1x, n2x, n1y, n2y;
    logic        [C-1:0]  dx, dy;
    sbi_pkg::t_slab_flags fx, fy;

    sbi_slab #(.COORD_BITS(C)) u_slab_x (
        .i_clk    (i_clk),
        .i_en1    (rdy1),
        .i_en2    (rdy2),
        .i_start  (sx),
        .i_end    (ex),
        .i_corner (bl),
        .i_extent (bw),
        .o_n1     (n1x),
        .o_n2     (n2x),
        .o_den    (dx),
        .o_flags  (fx)
    );

    sbi_slab #(.COORD_BITS(C)) u_slab_y (
        .i_clk    (i_clk),
        .i_en1    (rdy1),
        .i_en2    (rdy2),
        .i_start  (sy),
        .i_end    (ey),
        .i_corner (bt),
        .i_extent (bh),
        .o_n1     (n1y),
        .o_n2     (n2y),
        .o_den    (dy),
        .o_flags  (fy)
    );

    // Stage 3: cross products, with the axis flags carried alongside.
    logic signed [PW-1:0] p_xin_y, p_yout_x, p_yin_x, p_xout_y;
    sbi_pkg::t_slab_flags r_fx3, r_fy3;

    sbi_cross #(.COORD_BITS(C)) u_cross (
        .i_clk     (i_clk),
        .i_en      (rdy3),
        .i_n1x     (n1x),
        .i_n2x     (n2x),
        .i_dx      (dx),
        .i_n1y     (n1y),
        .i_n2y     (n2y),
        .i_dy      (dy),
        .o_x_in_y  (p_xin_y),
        .o_y_out_x (p_yout_x),
        .o_y_in_x  (p_yin_x),
        .o_x_out_y (p_xout_y)
    );

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_fx3 <= fx;
            r_fy3 <= fy;
        end
    end

    // Stage 4: the clipped interval is non-empty when each axis admits some
    // part of [0,1] and neither axis's entry lies after the other's exit.
    logic x_ok, y_ok, cross_ok, n_hit, r_hit;

    always_comb begin
        x_ok     = r_fx3.zero ? r_fx3.in_slab : (r_fx3.lo_ok && r_fx3.hi_ok);
        y_ok     = r_fy3.zero ? r_fy3.in_slab : (r_fy3.lo_ok && r_fy3.hi_ok);
        cross_ok = (r_fx3.zero || r_fy3.zero) ||
                   ((p_xin_y <= p_yout_x) && (p_yin_x <= p_xout_y));
        n_hit    = x_ok && y_ok && cross_ok;
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_hit <= n_hit;
        end
    end

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {7'b0000000, r_hit};

endmodule

@@ rtl/sbi_checker.sv @@
// ============================================================================
// Segment/box intersection - port checker
// Watches the top-level ports for stalls, back-pressure and latency, and
// checks a known hit case end to end.
// ============================================================================
module sbi_checker #(
    parameter int COORD_BITS = sbi_pkg::COORD_BITS_DEFAULT
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    s_axis_tvalid,
    input logic                    s_axis_tready,
    input logic [8*COORD_BITS-1:0] s_axis_tdata,
    input logic                    m_axis_tvalid,
    input logic                    m_axis_tready,
    input logic [7:0]              m_axis_tdata
);

    localparam int C = COORD_BITS;

    logic in_acc, corner_point;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Degenerate segment sitting exactly on the box's minimum corner.
    assign corner_point = (s_axis_tdata[C-1:0]     == s_axis_tdata[3*C-1:2*C]) &&
                          (s_axis_tdata[2*C-1:C]   == s_axis_tdata[4*C-1:3*C]) &&
                          (s_axis_tdata[C-1:0]     == s_axis_tdata[5*C-1:4*C]) &&
                          (s_axis_tdata[2*C-1:C]   == s_axis_tdata[6*C-1:5*C]);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // With nothing waiting at the output, the pipeline must take input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input refused with an empty output");

    // An accepted input comes out valid when the output keeps draining.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result missing after pipeline latency");

    // Touching the corner counts as a hit.
    a_corner_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && corner_point) ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        |=> m_axis_tvalid && m_axis_tdata[0])
        else $error("corner touch not reported as a hit");

endmodule

bind segment_box_intersect_top sbi_checker #(.COORD_BITS(COORD_BITS)) u_sbi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ dv/segment_box_intersect_top_test.sv @@
// ============================================================================
// Segment/box intersection - self-checking testbench
// Streams segment/box pairs into the block with bursty input traffic and a
// stalling output side, takes every hit flag from the directed table or from exact
// rational slab clipping, and compares each output transaction with the oldest prediction.
// A short table of directed cases comes first, then shaped random traffic.
// ============================================================================
module segment_box_intersect_top_test;

    localparam int CB            = sbi_pkg::COORD_BITS_DEFAULT;
    localparam int RANDOM_ITEMS  = 1227;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLDOFF_LEN   = 80;

    // How the expected hit of a stimulus row is obtained.
    localparam logic [1:0] WANT_MISS  = 2'd0;
    localparam logic [1:0] WANT_HIT   = 2'd1;
    localparam logic [1:0] WANT_MODEL = 2'd2;

    // One input transaction, laid out exactly as s_axis_tdata (first field lowest).
    typedef struct packed {
        logic [1:0]           pad;
        logic [CB-2:0]        box_height;
        logic [CB-2:0]        box_width;
        logic signed [CB-1:0] box_top;
        logic signed [CB-1:0] box_left;
        logic signed [CB-1:0] seg_end_y;
        logic signed [CB-1:0] seg_end_x;
        logic signed [CB-1:0] seg_start_y;
        logic signed [CB-1:0] seg_start_x;
    } t_seg_box;

    typedef struct packed {
        logic [1:0] want;
        t_seg_box   item;
    } t_case_row;

    // Exact fraction num/den with den > 0.
    typedef struct packed {
        logic signed [63:0] num;
        logic signed [63:0] den;
    } t_ratio;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [8*CB-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [7:0]        m_axis_tdata;

    // Travels alongside s_axis_tdata: where the expected hit comes from.
    logic [1:0]        stim_want;

    logic              pending_hits[$];
    t_case_row         case_table[$];
    int                mismatch_count;
    int                accepted_count;
    int                burst_left;
    int unsigned       cycle_count;

    segment_box_intersect_top #(
        .COORD_BITS(CB)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run limit reached with %0d hits outstanding", $realtime,
                     pending_hits.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Hit prediction
    // ------------------------------------------------------------------------

    // Sign of a - b for two fractions with positive denominators.
    function automatic int ratio_order(input t_ratio a, input t_ratio b);
        logic signed [63:0] lhs;
        logic signed [63:0] rhs;
        lhs = a.num * b.den;
        rhs = b.num * a.den;
        if (lhs > rhs) begin
            return 1;
        end
        if (lhs < rhs) begin
            return -1;
        end
        return 0;
    endfunction

    // Narrows the parameter interval [t_in, t_out] to one slab; 0 on a miss.
    function automatic logic slab_clip(input longint s, input longint e,
                                       input longint corner, input longint extent,
                                       inout t_ratio t_in, inout t_ratio t_out);
        longint delta;
        longint to_lo;
        longint to_hi;
        t_ratio cand;
        delta = e - s;
        // No motion along this axis: the coordinate must sit in the closed slab.
        if (delta == 0) begin
            return (s >= corner) && (s <= corner + extent);
        end
        to_lo = corner - s;
        to_hi = corner + extent - s;
        if (delta < 0) begin
            to_lo = -to_lo;
            to_hi = -to_hi;
            delta = -delta;
        end
        cand.den = delta;
        cand.num = (to_lo < to_hi) ? to_lo : to_hi;
        if (ratio_order(cand, t_in) > 0) begin
            t_in = cand;
        end
        cand.num = (to_lo < to_hi) ? to_hi : to_lo;
        if (ratio_order(cand, t_out) < 0) begin
            t_out = cand;
        end
        return ratio_order(t_in, t_out) <= 0;
    endfunction

    function automatic logic predict_hit(input t_seg_box it);
        t_ratio t_in;
        t_ratio t_out;
        logic   hit;
        t_in.num  = 0;
        t_in.den  = 1;
        t_out.num = 1;
        t_out.den = 1;
        hit = slab_clip($signed(it.seg_start_x), $signed(it.seg_end_x),
                        $signed(it.box_left), it.box_width, t_in, t_out);
        if (hit) begin
            hit = slab_clip($signed(it.seg_start_y), $signed(it.seg_end_y),
                            $signed(it.box_top), it.box_height, t_in, t_out);
        end
        return hit;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic signed [CB-1:0] to_coord(input int v);
        return v[CB-1:0];
    endfunction

    function automatic logic [CB-2:0] to_extent(input int v);
        return v[CB-2:0];
    endfunction

    // Uniform value in [-span, span].
    function automatic int jitter(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic add_row(input int sx, input int sy, input int ex, input int ey,
                           input int left, input int top, input int w, input int h,
                           input logic [1:0] want);
        t_case_row row;
        row                  = '0;
        row.want             = want;
        row.item.seg_start_x = to_coord(sx);
        row.item.seg_start_y = to_coord(sy);
        row.item.seg_end_x   = to_coord(ex);
        row.item.seg_end_y   = to_coord(ey);
        row.item.box_left    = to_coord(left);
        row.item.box_top     = to_coord(top);
        row.item.box_width   = to_extent(w);
        row.item.box_height  = to_extent(h);
        case_table.push_back(row);
    endtask

    // Offers one transaction and returns at the edge where it is accepted.
    // Bursts of random length are mostly separated by random idle gaps.
    task automatic offer(input t_seg_box it, input logic [1:0] want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it;
        stim_want     <= want;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // ------------------------------------------------------------------------
    // Sender: reset, directed table, shaped random traffic, end of run
    // ------------------------------------------------------------------------
    initial begin : sender
        t_seg_box it;
        int       kind;
        int       spread;
        int       cx;
        int       cy;
        int       n;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        stim_want     <= WANT_MODEL;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        //      sx      sy      ex      ey      left    top     width  height expected
        add_row(0,      0,      0,      0,      0,      0,      0,     0,     WANT_HIT);
        add_row(10,     10,     10,     10,     0,      0,      20,    20,    WANT_HIT);
        add_row(30,     10,     30,     10,     0,      0,      20,    20,    WANT_MISS);
        add_row(20,     20,     20,     20,     0,      0,      20,    20,    WANT_HIT);
        add_row(-5,     -100,   -5,     100,    0,      0,      20,    20,    WANT_MISS);
        add_row(0,      -100,   0,      100,    0,      0,      20,    20,    WANT_HIT);
        add_row(-100,   5,      100,    5,      0,      0,      20,    20,    WANT_HIT);
        add_row(100,    5,      -100,   5,      0,      0,      20,    20,    WANT_HIT);
        add_row(5,      5,      15,     15,     0,      0,      20,    20,    WANT_HIT);
        add_row(-100,   5,      -1,     5,      0,      0,      20,    20,    WANT_MISS);
        add_row(-100,   -100,   -50,    -50,    0,      0,      20,    20,    WANT_MISS);
        add_row(-10,    -10,    0,      0,      0,      0,      20,    20,    WANT_HIT);
        add_row(-10,    10,     10,     -10,    0,      0,      20,    20,    WANT_MODEL);
        add_row(-10,    9,      9,      -10,    0,      0,      20,    20,    WANT_MODEL);
        add_row(-32768, -32768, 32767,  32767,  -32768, -32768, 32767, 32767, WANT_MODEL);
        add_row(0,      0,      32767,  32767,  32767,  32767,  32767, 32767, WANT_MODEL);
        add_row(32767,  32767,  32767,  32767,  -32768, -32768, 32767, 32767, WANT_MODEL);
        add_row(32767,  32767,  32767,  32767,  0,      0,      32767, 32767, WANT_HIT);
        add_row(32767,  -32768, -32768, 32767,  -32768, -32768, 0,     0,     WANT_MODEL);
        add_row(0,      0,      32,     16,     16,     8,      0,     0,     WANT_MODEL);
        add_row(0,      0,      32,     16,     16,     9,      0,     0,     WANT_MODEL);
        add_row(-32768, -750,   32767,  -750,   -1000,  -1000,  500,   500,   WANT_MODEL);
        add_row(-32768, 20,     32767,  20,     -32768, 20,     0,     0,     WANT_MODEL);
        add_row(0,      -32768, 0,      32767,  -1,     -32768, 0,     32767, WANT_MODEL);

        foreach (case_table[i]) begin
            offer(case_table[i].item, case_table[i].want);
        end

        // Random part: some fully random pairs, most of them placed close to
        // the box so that hits, touches and near misses are all common.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            it   = '0;
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                it.seg_start_x = to_coord($urandom);
                it.seg_start_y = to_coord($urandom);
                it.seg_end_x   = to_coord($urandom);
                it.seg_end_y   = to_coord($urandom);
                it.box_left    = to_coord($urandom);
                it.box_top     = to_coord($urandom);
                it.box_width   = to_extent($urandom);
                it.box_height  = to_extent($urandom);
            end else begin
                spread = (kind < 6) ? 32 : 1024;
                cx = int'($urandom_range(0, 65535)) - 32768;
                cy = int'($urandom_range(0, 65535)) - 32768;
                it.box_left    = to_coord(cx + jitter(spread));
                it.box_top     = to_coord(cy + jitter(spread));
                it.box_width   = to_extent($urandom_range(0, spread));
                it.box_height  = to_extent($urandom_range(0, spread));
                it.seg_start_x = to_coord(cx + jitter(3 * spread));
                it.seg_start_y = to_coord(cy + jitter(3 * spread));
                it.seg_end_x   = to_coord(cx + jitter(3 * spread));
                it.seg_end_y   = to_coord(cy + jitter(3 * spread));
                // Axis-parallel segments.
                if (kind == 8) begin
                    if ($urandom_range(0, 1) == 0) begin
                        it.seg_end_x = it.seg_start_x;
                    end else begin
                        it.seg_end_y = it.seg_start_y;
                    end
                end
                // Point segments, and zero-size boxes grazed by the segment.
                if (kind == 9) begin
                    if ($urandom_range(0, 1) == 0) begin
                        it.seg_end_x = it.seg_start_x;
                        it.seg_end_y = it.seg_start_y;
                    end else begin
                        it.box_width   = '0;
                        it.box_height  = '0;
                        it.seg_start_x = it.box_left;
                        it.seg_start_y = it.box_top;
                    end
                end
            end
            offer(it, WANT_MODEL);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_hits.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall patterns that change every so often, plus two long
    // hold-offs while the sender keeps offering, so the pipeline fills up.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        int holdoffs_done;

        mode          = 0;
        mode_left     = 0;
        hold_left     = 0;
        holdoffs_done = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && holdoffs_done < 2 &&
                accepted_count >= 400 + 600 * holdoffs_done) begin
                hold_left = HOLDOFF_LEN;
                holdoffs_done++;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                case (mode)
                    0: begin
                        m_axis_tready <= 1'b1;
                    end
                    1: begin
                        m_axis_tready <= ($urandom_range(0, 1) == 1);
                    end
                    2: begin
                        m_axis_tready <= ($urandom_range(0, 7) != 0);
                    end
                    default: begin
                        m_axis_tready <= ((mode_left % 6) < 2);
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard: predicts on every accepted input transaction and checks
    // every accepted output transaction against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        logic want_hit;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_hits.size() == 0) begin
                    $display("%0t: result with nothing outstanding, %s hit=%0b",
                             $realtime, "expected none, actual", m_axis_tdata[0]);
                    mismatch_count++;
                end else begin
                    want_hit = pending_hits.pop_front();
                    if (m_axis_tdata[0] !== want_hit) begin
                        $display("%0t: hit mismatch, expected %0b, actual %0b",
                                 $realtime, want_hit, m_axis_tdata[0]);
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (stim_want == WANT_MODEL) begin
                    pending_hits.push_back(predict_hit(s_axis_tdata));
                end else begin
                    pending_hits.push_back(stim_want == WANT_HIT);
                end
                accepted_count <= accepted_count + 1;
            end
        end
    end

endmodule

@@ segment_box_intersect_top.f @@
rtl/sbi_pkg.sv
rtl/sbi_slab.sv
rtl/sbi_cross.sv
rtl/segment_box_intersect_top.sv
rtl/sbi_checker.sv
dv/segment_box_intersect_top_test.sv
